### hw/rtl/lbdq_pkg.sv
// lbdq_pkg: shared types and codes for the bounded list deque.
// Holds the command, status and sequencer state encodings and the capacity width and reset value.
// No dependencies.
`default_nettype none

package lbdq_pkg;

    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        CMD_APPEND   = 3'd0,
        CMD_PREPEND  = 3'd1,
        CMD_DELETE   = 3'd2,
        CMD_POP_HEAD = 3'd3,
        CMD_POP_TAIL = 3'd4,
        CMD_PEEK     = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT,
        S_FIN,
        S_RD_HEAD,
        S_RD_TAIL
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/lbdq_store.sv
// lbdq_store: entry memory of the list, one write and one read port.
// Read data is registered. No package dependency.
`default_nettype none

module lbdq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/bounded_list_deque_with_match_delete_core.sv
// Bounded list deque: top level with sequencer, capacity register and result register.
// Depends on lbdq_pkg and lbdq_store.
//
// Usage:
//   Command channel: drive i_cmd and i_value with start high; the command is
//   taken at a clock edge where start is high and busy is low. busy stays high
//   while the command is worked on.
//   Result channel: o_strobe is high for exactly one cycle with o_status,
//   o_popped_value, o_entry_count, o_head_value and o_tail_value. The receiver
//   cannot stall; the result must be taken in that cycle.
//   Capacity: i_cfg_we with i_cfg_wdata writes the capacity register; write it
//   only while the block is idle.
//   Timing: after the accepting edge the sequencer steps through EXEC, then
//   POP_WAIT for a pop or SCAN and, if needed, SHIFT for a match delete, then
//   FIN, RD_HEAD and RD_TAIL; o_strobe is registered from RD_TAIL. busy falls
//   in the strobe cycle, so a new command can be taken at the end of it. The
//   delete scan and the compaction after it move one entry per cycle through
//   the single read port of the entry memory; head and tail are read back from it at the end.
//   Reset: the list is empty, head index zero, capacity 16; memory contents
//   are not cleared, entries are only read after they are written.
`default_nettype none

module bounded_list_deque_with_match_delete_core
    import lbdq_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_popped_value,
    output logic [4:0]              o_entry_count,
    output logic signed [31:0]      o_head_value,
    output logic signed [31:0]      o_tail_value
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LOG_W = CNT_W + 1;
    localparam int SUM_W = LOG_W + 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // physical slot of a logical position, modulo the store depth
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                              input logic [LOG_W-1:0] pos);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(pos);
        if (s >= SUM_W'(MAX_ENTRIES)) begin
            s = s - SUM_W'(MAX_ENTRIES);
        end
        return s[IDX_W-1:0];
    endfunction

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [DATA_WIDTH-1:0] r_popped, n_popped;
    logic [DATA_WIDTH-1:0] r_head_val, n_head_val;
    logic [DATA_WIDTH-1:0] r_tail_val, n_tail_val;
    logic                  r_strobe, n_strobe;
    logic [CFG_W-1:0]      r_capacity;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic                  full, empty, match, more, more2;
    logic [LOG_W-1:0]      count_l, idx_l;
    logic [IDX_W-1:0]      prev_head;

    lbdq_store #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (DATA_WIDTH),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign count_l   = LOG_W'(r_count);
    assign idx_l     = LOG_W'(r_idx);
    assign full      = (CMP_W'(r_count) >= CMP_W'(r_capacity))
                    || (r_count >= CNT_W'(MAX_ENTRIES));
    assign empty     = (r_count == '0);
    assign match     = (mem_rdata == r_value);
    assign more      = (idx_l + LOG_W'(1)) < count_l;
    assign more2     = (idx_l + LOG_W'(2)) < count_l;
    assign prev_head = (r_head == '0) ? IDX_W'(MAX_ENTRIES - 1) : r_head - IDX_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_POP_HEAD, CMD_POP_TAIL: n_state = empty ? S_FIN : S_POP_WAIT;
                    CMD_DELETE:                 n_state = empty ? S_FIN : S_SCAN;
                    default:                    n_state = S_FIN;
                endcase
            end
            S_POP_WAIT: n_state = S_FIN;
            S_SCAN: begin
                if (match) begin
                    n_state = ((r_idx != '0) && more) ? S_SHIFT : S_FIN;
                end else begin
                    n_state = more ? S_SCAN : S_FIN;
                end
            end
            S_SHIFT:   n_state = more2 ? S_SHIFT : S_FIN;
            S_FIN:     n_state = S_RD_HEAD;
            S_RD_HEAD: n_state = S_RD_TAIL;
            S_RD_TAIL: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_status   = r_status;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_popped   = r_popped;
        n_head_val = r_head_val;
        n_tail_val = r_tail_val;
        n_strobe   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot(r_head, idx_l);
        mem_wdata  = mem_rdata;
        mem_raddr  = r_head;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_value  = DATA_WIDTH'($unsigned(i_value));
                    n_status = ST_OK;
                    n_popped = '0;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = slot(r_head, count_l);
                            mem_wdata = r_value;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    CMD_PREPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = prev_head;
                            mem_wdata = r_value;
                            n_head    = prev_head;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    CMD_DELETE: begin
                        n_status  = ST_NOT_FOUND;
                        n_idx     = '0;
                        mem_raddr = r_head;
                    end
                    CMD_POP_HEAD: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end
                        mem_raddr = r_head;
                    end
                    CMD_POP_TAIL: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end
                        mem_raddr = slot(r_head, count_l - LOG_W'(1));
                    end
                    CMD_PEEK: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP_WAIT: begin
                n_popped = mem_rdata;
                n_count  = r_count - CNT_W'(1);
                if (r_cmd == CMD_POP_HEAD) begin
                    n_head = slot(r_head, LOG_W'(1));
                end
            end
            S_SCAN: begin
                // fetch the next entry; on a match it is the first one to move down
                mem_raddr = slot(r_head, idx_l + LOG_W'(1));
                if (match) begin
                    n_status = ST_OK;
                    if (r_idx == '0) begin
                        n_head  = slot(r_head, LOG_W'(1));
                        n_count = r_count - CNT_W'(1);
                    end else if (!more) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end else if (more) begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle one place lower, read ahead
                mem_we    = 1'b1;
                mem_waddr = slot(r_head, idx_l);
                mem_wdata = mem_rdata;
                mem_raddr = slot(r_head, idx_l + LOG_W'(2));
                if (more2) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_FIN: begin
                if (empty) begin
                    n_head = '0;
                end
                mem_raddr = r_head;
            end
            S_RD_HEAD: begin
                n_head_val = empty ? '0 : mem_rdata;
                mem_raddr  = slot(r_head, count_l - LOG_W'(1));
            end
            S_RD_TAIL: begin
                n_tail_val = empty ? '0 : mem_rdata;
                n_strobe   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
            r_capacity <= CAP_RESET;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_value    <= n_value;
        r_status   <= n_status;
        r_idx      <= n_idx;
        r_popped   <= n_popped;
        r_head_val <= n_head_val;
        r_tail_val <= n_tail_val;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_popped_value = 32'(r_popped);
    assign o_entry_count  = 5'(r_count);
    assign o_head_value   = 32'(r_head_val);
    assign o_tail_value   = 32'(r_tail_val);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_EXEC || r_state == S_SHIFT))
        else $error("entry memory written outside insert or compaction");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_count <= CNT_W'(MAX_ENTRIES)))
        else $error("entry count above store depth");

endmodule

`default_nettype wire
